// ===== hdl/mi2c_pkg.sv =====
// Shared constants for the clamped 2x2 matrix inverse.
// No dependencies; imported by the top level.
package mi2c_pkg;

   // Width and reset value of the determinant floor register.
   localparam int unsigned FLOOR_WIDTH = 31;
   localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET = 31'd66;

   // Result lanes: r00, r01, r10, r11.
   localparam int unsigned LANES = 4;
   localparam int unsigned LANE_R00 = 0;
   localparam int unsigned LANE_R01 = 1;
   localparam int unsigned LANE_R10 = 2;
   localparam int unsigned LANE_R11 = 3;

endpackage

// ===== hdl/mi2c_req_if.sv =====
// Request channel carrying one 2x2 matrix word.
// No dependencies.
interface mi2c_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;

   modport source (output valid, m00, m01, m10, m11, input ready);
   modport sink   (input valid, m00, m01, m10, m11, output ready);
endinterface

// ===== hdl/mi2c_rsp_if.sv =====
// Response channel carrying one inverse matrix word with flags.
// No dependencies.
interface mi2c_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r00;
   logic signed [DATA_WIDTH-1:0] r01;
   logic signed [DATA_WIDTH-1:0] r10;
   logic signed [DATA_WIDTH-1:0] r11;
   logic                         det_clamped;
   logic                         result_saturated;

   modport source (output valid, r00, r01, r10, r11, det_clamped, result_saturated,
                   input ready);
   modport sink   (input valid, r00, r01, r10, r11, det_clamped, result_saturated,
                   output ready);
endinterface

// ===== hdl/matrix_inverse_2x2_clamped.sv =====
// Pipelined 2x2 fixed-point matrix inverse with a determinant floor.
// Depends on mi2c_pkg, mi2c_req_if and mi2c_rsp_if.
//
// A new matrix word is taken every cycle while the pipeline advances, and each
// word passes through one register stage for the sign split, one for the two
// magnitude products, one for the determinant sum, one for the truncation and
// floor clamp, then one stage per quotient bit in four parallel restoring
// dividers, and the output register. The whole pipeline advances together; it
// holds while a finished word waits on rsp. The floor register may only be
// written while idle.
module matrix_inverse_2x2_clamped
   import mi2c_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   mi2c_req_if.sink               req,
   mi2c_rsp_if.source             rsp,
   input  logic                   csr_wr_en,
   input  logic [FLOOR_WIDTH-1:0] csr_wr_data
);

   localparam int PW   = 2 * DATA_WIDTH;              // product width
   localparam int SW   = PW + 1;                      // determinant sum width
   localparam int DETW = SW - FRAC_BITS;              // truncated determinant
   localparam int DVW  = (DETW > FLOOR_WIDTH) ? DETW : FLOOR_WIDTH;
   localparam int NW   = DATA_WIDTH + FRAC_BITS;      // numerator and quotient
   localparam logic [NW-1:0] HALF = NW'(1) << (DATA_WIDTH - 1);

   logic                   adv;
   logic [FLOOR_WIDTH-1:0] floor_ff;

   // Stage A: sign and magnitude.
   logic                  a_v_ff;
   logic [DATA_WIDTH-1:0] a_mag_ff [LANES];
   logic                  a_neg_ff [LANES];
   logic [DATA_WIDTH-1:0] a_mag_in [LANES];
   logic                  a_neg_in [LANES];

   // Stage B: products.
   logic                  b_v_ff;
   logic [PW-1:0]         b_p1_ff, b_p2_ff, b_p1_in, b_p2_in;
   logic                  b_s1_ff, b_s2_ff;
   logic [DATA_WIDTH-1:0] b_nmag_ff [LANES];
   logic                  b_nneg_ff [LANES];

   // Stage C: exact determinant.
   logic                  c_v_ff;
   logic [SW-1:0]         c_det_ff, c_det_in;
   logic                  c_neg_ff, c_neg_in;
   logic [DATA_WIDTH-1:0] c_nmag_ff [LANES];
   logic                  c_nneg_ff [LANES];

   // Divider rows: row 0 is written by the clamp stage.
   logic           v_ff   [NW+1];
   logic           clp_ff [NW+1];
   logic [DVW-1:0] dv_ff  [NW+1];
   logic [DVW-1:0] rem_ff [NW+1][LANES];
   logic [NW-1:0]  quo_ff [NW+1][LANES];
   logic [NW-1:0]  num_ff [NW+1][LANES];
   logic           rng_ff [NW+1][LANES];

   logic           clp_in;
   logic [DVW-1:0] dv_in;
   logic           dneg_in;
   logic [DVW-1:0] rem_in [NW][LANES];
   logic [NW-1:0]  quo_in [NW][LANES];

   // Output register.
   logic                  out_v_ff;
   logic [DATA_WIDTH-1:0] res_ff [LANES];
   logic [DATA_WIDTH-1:0] res_in [LANES];
   logic                  clamp_ff, sat_ff, sat_in;

   // The pipeline moves whenever the output word is empty or being taken.
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // Floor register.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
      end else if (csr_wr_en) begin
         floor_ff <= csr_wr_data;
      end
   end

   // Sign split of the incoming elements.
   always_comb begin
      logic [DATA_WIDTH-1:0] raw [LANES];
      raw[0] = req.m00;
      raw[1] = req.m01;
      raw[2] = req.m10;
      raw[3] = req.m11;
      for (int i = 0; i < LANES; i++) begin
         a_neg_in[i] = raw[i][DATA_WIDTH-1];
         a_mag_in[i] = a_neg_in[i] ? (~raw[i] + DATA_WIDTH'(1)) : raw[i];
      end
   end

   // Magnitude products.
   assign b_p1_in = PW'(a_mag_ff[0]) * PW'(a_mag_ff[3]);
   assign b_p2_in = PW'(a_mag_ff[2]) * PW'(a_mag_ff[1]);

   // Determinant in sign and magnitude form.
   always_comb begin
      if (b_s1_ff != b_s2_ff) begin
         c_det_in = SW'(b_p1_ff) + SW'(b_p2_ff);
         c_neg_in = b_s1_ff;
      end else if (b_p1_ff >= b_p2_ff) begin
         c_det_in = SW'(b_p1_ff) - SW'(b_p2_ff);
         c_neg_in = b_s1_ff;
      end else begin
         c_det_in = SW'(b_p2_ff) - SW'(b_p1_ff);
         c_neg_in = !b_s1_ff;
      end
   end

   // Truncation, zero sign rule and floor clamp.
   always_comb begin
      logic [DVW-1:0] dsh;
      logic [DVW-1:0] flr;
      dsh     = DVW'(c_det_ff[SW-1:FRAC_BITS]);
      flr     = (floor_ff == '0) ? DVW'(1) : DVW'(floor_ff);
      dneg_in = c_neg_ff || (dsh == '0);
      clp_in  = dsh < flr;
      dv_in   = clp_in ? flr : dsh;
   end

   // One restoring division step per row and lane.
   always_comb begin
      logic [DVW:0] t;
      for (int k = 0; k < NW; k++) begin
         for (int j = 0; j < LANES; j++) begin
            t = {rem_ff[k][j], num_ff[k][j][NW-1-k]};
            if (t >= {1'b0, dv_ff[k]}) begin
               t            = t - {1'b0, dv_ff[k]};
               quo_in[k][j] = {quo_ff[k][j][NW-2:0], 1'b1};
            end else begin
               quo_in[k][j] = {quo_ff[k][j][NW-2:0], 1'b0};
            end
            rem_in[k][j] = t[DVW-1:0];
         end
      end
   end

   // Saturation and sign of the final quotients.
   always_comb begin
      logic [NW-1:0] lim;
      logic [NW-1:0] m;
      sat_in = 1'b0;
      for (int j = 0; j < LANES; j++) begin
         lim = rng_ff[NW][j] ? HALF : (HALF - NW'(1));
         if (quo_ff[NW][j] > lim) begin
            sat_in = 1'b1;
            m      = lim;
         end else begin
            m = quo_ff[NW][j];
         end
         res_in[j] = rng_ff[NW][j] ? DATA_WIDTH'(~m + NW'(1)) : DATA_WIDTH'(m);
      end
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int r = 0; r <= NW; r++) begin
            v_ff[r] <= 1'b0;
         end
      end else if (adv) begin
         a_v_ff  <= req.valid;
         b_v_ff  <= a_v_ff;
         c_v_ff  <= b_v_ff;
         v_ff[0] <= c_v_ff;
         for (int r = 0; r < NW; r++) begin
            v_ff[r+1] <= v_ff[r];
         end
         out_v_ff <= v_ff[NW];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            a_mag_ff[i] <= a_mag_in[i];
            a_neg_ff[i] <= a_neg_in[i];
         end
         b_p1_ff <= b_p1_in;
         b_p2_ff <= b_p2_in;
         b_s1_ff <= a_neg_ff[0] ^ a_neg_ff[3];
         b_s2_ff <= a_neg_ff[2] ^ a_neg_ff[1];
         b_nmag_ff[LANE_R00] <= a_mag_ff[3];
         b_nneg_ff[LANE_R00] <= a_neg_ff[3];
         b_nmag_ff[LANE_R01] <= a_mag_ff[1];
         b_nneg_ff[LANE_R01] <= !a_neg_ff[1];
         b_nmag_ff[LANE_R10] <= a_mag_ff[2];
         b_nneg_ff[LANE_R10] <= !a_neg_ff[2];
         b_nmag_ff[LANE_R11] <= a_mag_ff[0];
         b_nneg_ff[LANE_R11] <= a_neg_ff[0];
         c_det_ff <= c_det_in;
         c_neg_ff <= c_neg_in;
         for (int i = 0; i < LANES; i++) begin
            c_nmag_ff[i] <= b_nmag_ff[i];
            c_nneg_ff[i] <= b_nneg_ff[i];
         end
         clp_ff[0] <= clp_in;
         dv_ff[0]  <= dv_in;
         for (int j = 0; j < LANES; j++) begin
            rem_ff[0][j] <= '0;
            quo_ff[0][j] <= '0;
            num_ff[0][j] <= {c_nmag_ff[j], {FRAC_BITS{1'b0}}};
            rng_ff[0][j] <= c_nneg_ff[j] ^ dneg_in;
         end
         for (int r = 0; r < NW; r++) begin
            clp_ff[r+1] <= clp_ff[r];
            dv_ff[r+1]  <= dv_ff[r];
            for (int j = 0; j < LANES; j++) begin
               rem_ff[r+1][j] <= rem_in[r][j];
               quo_ff[r+1][j] <= quo_in[r][j];
               num_ff[r+1][j] <= num_ff[r][j];
               rng_ff[r+1][j] <= rng_ff[r][j];
            end
         end
         for (int j = 0; j < LANES; j++) begin
            res_ff[j] <= res_in[j];
         end
         clamp_ff <= clp_ff[NW];
         sat_ff   <= sat_in;
      end
   end

   // Response word.
   assign rsp.valid            = out_v_ff;
   assign rsp.r00              = res_ff[LANE_R00];
   assign rsp.r01              = res_ff[LANE_R01];
   assign rsp.r10              = res_ff[LANE_R10];
   assign rsp.r11              = res_ff[LANE_R11];
   assign rsp.det_clamped      = clamp_ff;
   assign rsp.result_saturated = sat_ff;

endmodule

// ===== tb/matrix_inverse_2x2_clamped_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the clamped 2x2 fixed-point matrix inverse.
// Depends on mi2c_pkg, mi2c_req_if, mi2c_rsp_if and matrix_inverse_2x2_clamped.
// A directed table, then constrained-by-hand random words, against an inverse predictor.
module matrix_inverse_2x2_clamped_tb;
   import mi2c_pkg::*;

   typedef logic signed [31:0] elem_type;

   typedef struct packed {
      elem_type r00;
      elem_type r01;
      elem_type r10;
      elem_type r11;
      logic     det_clamped;
      logic     result_saturated;
   } inverse_type;

   typedef struct {
      elem_type    m00, m01, m10, m11;
      logic        typed;
      inverse_type want;
   } directed_row_type;

   localparam elem_type EMAX = 32'sh7FFF_FFFF;
   localparam elem_type EMIN = -32'sh7FFF_FFFF - 1;
   localparam elem_type ONE  = 32'sh0001_0000;
   localparam int       DRAIN_CYCLES = 60;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [FLOOR_WIDTH-1:0] csr_wr_data;

   mi2c_req_if #(.DATA_WIDTH(32)) req_ch ();
   mi2c_rsp_if #(.DATA_WIDTH(32)) rsp_ch ();

   matrix_inverse_2x2_clamped u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Floor as the block holds it, and the inverses still owed by the block.
   logic [FLOOR_WIDTH-1:0] floor_now;
   inverse_type            pending_inverses[$];
   int                     fail_count;
   bit                     no_idle;
   int                     rsp_stall;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Numerator over the clamped determinant, truncated and saturated.
   function automatic elem_type divide_lane(logic signed [127:0] num, logic [127:0] dmag,
                                            logic dneg, inout logic sat);
      logic        nneg;
      logic        rneg;
      logic [127:0] nmag;
      logic [127:0] q;
      logic [127:0] lim;
      nneg = num < 0;
      nmag = nneg ? -num : num;
      q    = (nmag << 16) / dmag;
      rneg = nneg ^ dneg;
      lim  = rneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
         q   = lim;
         sat = 1'b1;
      end
      return rneg ? -q[31:0] : q[31:0];
   endfunction

   // Inverse by the adjugate with the determinant floor applied.
   function automatic inverse_type inverse_of(elem_type a00, elem_type a01, elem_type a10,
                                              elem_type a11, logic [FLOOR_WIDTH-1:0] fl);
      logic signed [127:0] w00, w01, w10, w11, det;
      logic [127:0] dmag, flw;
      logic         dneg, sat;
      inverse_type  res;
      w00 = a00; w01 = a01; w10 = a10; w11 = a11;
      det  = w00 * w11 - w10 * w01;
      dneg = det < 0;
      dmag = (dneg ? -det : det) >> 16;
      // A determinant truncated to zero counts as negative.
      if (dmag == 0) dneg = 1'b1;
      flw = (fl == 0) ? 128'd1 : 128'(fl);
      res.det_clamped = dmag < flw;
      if (res.det_clamped) dmag = flw;
      sat = 1'b0;
      res.r00 = divide_lane(w11, dmag, dneg, sat);
      res.r01 = divide_lane(-w01, dmag, dneg, sat);
      res.r10 = divide_lane(-w10, dmag, dneg, sat);
      res.r11 = divide_lane(w00, dmag, dneg, sat);
      res.result_saturated = sat;
      return res;
   endfunction

   // Every accepted request word queues its inverse.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         pending_inverses.push_back(inverse_of(req_ch.m00, req_ch.m01, req_ch.m10,
                                               req_ch.m11, floor_now));
   end

   // Each accepted response word is checked against the oldest owed inverse.
   always @(posedge clock) begin
      inverse_type want;
      inverse_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.r00, rsp_ch.r01, rsp_ch.r10, rsp_ch.r11,
                 rsp_ch.det_clamped, rsp_ch.result_saturated};
         if (pending_inverses.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $realtime, got);
            fail_count++;
         end else begin
            want = pending_inverses.pop_front();
            if (got.r00 !== want.r00)
               $display("%0t: r00 expected %0d actual %0d", $realtime, want.r00, got.r00);
            if (got.r01 !== want.r01)
               $display("%0t: r01 expected %0d actual %0d", $realtime, want.r01, got.r01);
            if (got.r10 !== want.r10)
               $display("%0t: r10 expected %0d actual %0d", $realtime, want.r10, got.r10);
            if (got.r11 !== want.r11)
               $display("%0t: r11 expected %0d actual %0d", $realtime, want.r11, got.r11);
            if (got.det_clamped !== want.det_clamped)
               $display("%0t: det_clamped expected %b actual %b", $realtime,
                        want.det_clamped, got.det_clamped);
            if (got.result_saturated !== want.result_saturated)
               $display("%0t: result_saturated expected %b actual %b", $realtime,
                        want.result_saturated, got.result_saturated);
            if (got !== want) fail_count++;
         end
      end
   end

   // Receiver stalls for a random number of cycles after each word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= (rsp_stall == 0);
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_stall = no_idle ? 0 : $urandom_range(0, 6);
         rsp_ch.ready <= (rsp_stall == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Drives one matrix word after a random gap and holds it until taken.
   task automatic send_matrix(elem_type a00, elem_type a01, elem_type a10, elem_type a11);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.m00   <= a00;
      req_ch.m01   <= a01;
      req_ch.m10   <= a10;
      req_ch.m11   <= a11;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Lets every owed inverse arrive, then a margin for the pipeline.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_floor(logic [FLOOR_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      floor_now    = value;
      @(posedge clock);
   endtask

   // Random word: full range, small Q16.16 values, or a nearly singular matrix.
   task automatic send_random_matrix();
      elem_type a00, a01, a10, a11;
      int       k;
      case ($urandom_range(0, 3))
         0: begin
            a00 = $urandom; a01 = $urandom; a10 = $urandom; a11 = $urandom;
         end
         1: begin
            a00 = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
            a01 = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
            a10 = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
            a11 = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
         end
         default: begin
            // Second row a multiple of the first, plus a little noise.
            k   = $signed($urandom_range(0, 16)) - 8;
            a00 = $signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000;
            a01 = $signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000;
            a10 = a00 * k + $signed($urandom_range(0, 64)) - 32;
            a11 = a01 * k + $signed($urandom_range(0, 64)) - 32;
         end
      endcase
      send_matrix(a00, a01, a10, a11);
   endtask

   directed_row_type directed_rows[] = '{
      '{ONE, 0, 0, ONE, 1'b1, '{ONE, 0, 0, ONE, 1'b0, 1'b0}},
      '{0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0}},
      '{EMAX, EMAX, EMAX, EMAX, 1'b1, '{EMIN, EMAX, EMAX, EMIN, 1'b1, 1'b1}},
      '{EMIN, EMIN, EMIN, EMIN, 1'b0, '0},
      '{EMIN, EMAX, EMIN, EMAX, 1'b0, '0},
      '{EMIN, 0, 0, EMIN, 1'b0, '0},
      '{EMAX, EMIN, EMIN, EMAX, 1'b0, '0},
      '{ONE, EMIN, EMIN, ONE, 1'b0, '0},
      '{2 * ONE, 0, 0, 2 * ONE, 1'b0, '0},
      '{0, ONE, ONE, 0, 1'b0, '0},
      '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 1'b0, '0},
      '{-ONE, 0, 0, ONE, 1'b0, '0},
      '{1, 0, 0, 1, 1'b0, '0},
      '{ONE, ONE, ONE, ONE + 1, 1'b0, '0},
      '{256, 0, 0, 256, 1'b0, '0},
      '{-1, 0, 0, -1, 1'b0, '0},
      '{EMAX, 1, -1, EMAX, 1'b0, '0},
      '{ONE / 2, -ONE, ONE, ONE / 3, 1'b0, '0}
   };

   logic [FLOOR_WIDTH-1:0] floor_plan[] = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd65536, 31'd0};

   // Main sequence: directed table and random words at reset floor, then a phase per floor setting.
   initial begin
      inverse_type row_pred;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.m00   <= '0;
      req_ch.m01   <= '0;
      req_ch.m10   <= '0;
      req_ch.m11   <= '0;
      floor_now     = FLOOR_RESET;
      fail_count    = 0;
      no_idle       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_matrix(directed_rows[i].m00, directed_rows[i].m01,
                     directed_rows[i].m10, directed_rows[i].m11);
         drain();
         // Rows with typed values also cross-check the predictor itself.
         row_pred = inverse_of(directed_rows[i].m00, directed_rows[i].m01,
                               directed_rows[i].m10, directed_rows[i].m11, floor_now);
         if (directed_rows[i].typed && row_pred !== directed_rows[i].want) begin
            $display("%0t: row %0d expected %h actual %h", $realtime, i,
                     directed_rows[i].want, row_pred);
            fail_count++;
         end
      end
      repeat (120) send_random_matrix();
      drain();

      foreach (floor_plan[p]) begin
         write_floor(p == 4 ? FLOOR_WIDTH'($urandom_range(2, 1 << 20)) : floor_plan[p]);
         no_idle = (p == 1);
         repeat (120) send_random_matrix();
         drain();
      end
      write_floor(FLOOR_RESET);
      no_idle = 1'b0;
      repeat (30) send_random_matrix();
      drain();

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
